// ===== hdl/rbr_pkg.sv =====
// rbr_pkg: shared constants and types of the reciprocal bound relaxation block
// used by every module under hdl; no dependencies
package rbr_pkg;

   localparam int NEURONS = 256;
   localparam int IDX_W   = 8;
   localparam int TOL_W   = 16;
   localparam int QUO_W   = 32;
   localparam int DIV_NW  = 62;
   localparam int DIV_LAT = QUO_W + 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;

   localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] QMIN = 32'h8000_0000;

   typedef enum logic {
      ACT_RELAX = 1'b0,
      ACT_SUBST = 1'b1
   } action_type;

   // classified item handed from the front to the back
   typedef struct packed {
      action_type       action;
      logic [IDX_W-1:0] neuron;
      logic             status;
      logic [31:0]      lo;
      logic [31:0]      hi;
      logic [31:0]      mid;
      logic             lo_inf;
      logic             lo_zero;
      logic             hi_inf;
      logic             hi_zero;
      logic             mid_inf;
      logic             mid_zero;
      logic             equal;
      logic [31:0]      wl;
      logic [31:0]      wu;
   } job_type;

   typedef struct packed {
      logic        status;
      logic [31:0] bound_lower;
      logic [31:0] bound_upper;
      logic [31:0] low_slope;
      logic [31:0] low_offset;
      logic [31:0] high_slope;
      logic [31:0] high_offset;
      logic [31:0] lower_coeff_delta;
      logic [31:0] lower_bias_delta;
      logic [31:0] upper_coeff_delta;
      logic [31:0] upper_bias_delta;
   } rsp_type;

endpackage

// ===== hdl/rbr_front.sv =====
// rbr_front: input register and classification of relax and substitute items
// depends on rbr_pkg
module rbr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      action,
   input  logic [rbr_pkg::IDX_W-1:0] neuron,
   input  logic [31:0]               source_lower,
   input  logic [31:0]               source_upper,
   input  logic [31:0]               weight_lower,
   input  logic [31:0]               weight_upper,
   input  logic [rbr_pkg::TOL_W-1:0] tolerance,
   output logic                      q_push,
   output rbr_pkg::job_type          q_data,
   input  logic                      q_full
);

   typedef struct packed {
      logic                      action;
      logic [rbr_pkg::IDX_W-1:0] neuron;
      logic [31:0]               lo;
      logic [31:0]               hi;
      logic [31:0]               wl;
      logic [31:0]               wu;
   } raw_type;

   raw_type     f_ff;
   logic        f_v_ff, f_v_in;
   logic        accept;
   logic [31:0] loc, hic, tol32;
   logic [32:0] diff, absd, sum;

   assign full   = f_v_ff && q_full;
   assign accept = push && !full;
   assign f_v_in = accept || (f_v_ff && q_full);
   assign q_push = f_v_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= f_v_in;
      end
      if (accept) begin
         f_ff <= '{action, neuron, source_lower, source_upper, weight_lower, weight_upper};
      end
   end

   // negative bounds clamp to zero and raise the flag
   always_comb begin
      tol32 = {16'b0, tolerance};
      loc   = f_ff.lo[31] ? 32'b0 : f_ff.lo;
      hic   = f_ff.hi[31] ? 32'b0 : f_ff.hi;
      diff  = {1'b0, hic} - {1'b0, loc};
      absd  = diff[32] ? (33'd0 - diff) : diff;
      sum   = {1'b0, loc} + {1'b0, hic};

      q_data.action   = rbr_pkg::action_type'(f_ff.action);
      q_data.neuron   = f_ff.neuron;
      q_data.status   = f_ff.lo[31] | f_ff.hi[31];
      q_data.lo       = loc;
      q_data.hi       = hic;
      q_data.lo_inf   = (loc == rbr_pkg::QMAX);
      q_data.hi_inf   = (hic == rbr_pkg::QMAX);
      q_data.lo_zero  = (loc <= tol32);
      q_data.hi_zero  = (hic <= tol32);
      q_data.mid      = (q_data.lo_inf || q_data.hi_inf) ? rbr_pkg::QMAX : sum[32:1];
      q_data.mid_inf  = (q_data.mid == rbr_pkg::QMAX);
      q_data.mid_zero = (q_data.mid <= tol32);
      q_data.equal    = (absd <= {1'b0, tol32});
      q_data.wl       = f_ff.wl;
      q_data.wu       = f_ff.wu;
   end

endmodule

// ===== hdl/rbr_queue.sv =====
// rbr_queue: short queue of classified items between front and back
// depends on rbr_pkg
module rbr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbr_pkg::job_type wdata,
   output logic             full,
   input  logic             pop,
   output rbr_pkg::job_type rdata,
   output logic             empty
);

   rbr_pkg::job_type              mem_ff [rbr_pkg::QDEPTH];
   logic [rbr_pkg::QPTR_W-1:0]    wptr_ff, rptr_ff;
   logic [rbr_pkg::QPTR_W:0]      cnt_ff, cnt_in;
   logic                          do_push, do_pop;

   assign full    = (cnt_ff == (rbr_pkg::QPTR_W+1)'(rbr_pkg::QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/rbr_divider.sv =====
// rbr_divider: pipelined restoring divider, one quotient bit per stage
// 32-bit quotient with a flag for quotients of 2^32 and above; depends on rbr_pkg
module rbr_divider (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rbr_pkg::DIV_NW-1:0] num,
   input  logic [rbr_pkg::DIV_NW-1:0] den,
   output logic [rbr_pkg::QUO_W-1:0]  quo,
   output logic                       ovf
);

   localparam int NW = rbr_pkg::DIV_NW;
   localparam int ST = rbr_pkg::QUO_W;

   logic [NW-1:0] rem_ff [ST+1];
   logic [NW-1:0] den_ff [ST+1];
   logic [ST-1:0] low_ff [ST+1];
   logic [ST-1:0] quo_ff [ST+1];
   logic          ovf_ff [ST+1];

   logic [NW-1:0] rem_in [ST];
   logic [ST-1:0] low_in [ST];
   logic [ST-1:0] quo_in [ST];
   logic [NW:0]   trial  [ST];
   logic          ge     [ST];

   always_comb begin
      for (int s = 0; s < ST; s++) begin
         trial[s]  = {rem_ff[s], low_ff[s][ST-1]};
         ge[s]     = (trial[s] >= {1'b0, den_ff[s]});
         rem_in[s] = ge[s] ? NW'(trial[s] - {1'b0, den_ff[s]}) : trial[s][NW-1:0];
         quo_in[s] = {quo_ff[s][ST-2:0], ge[s]};
         low_in[s] = {low_ff[s][ST-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // upper part of the dividend seeds the remainder
         rem_ff[0] <= {{ST{1'b0}}, num[NW-1:ST]};
         den_ff[0] <= den;
         low_ff[0] <= num[ST-1:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({{ST{1'b0}}, num[NW-1:ST]} >= den);
         for (int s = 0; s < ST; s++) begin
            rem_ff[s+1] <= rem_in[s];
            den_ff[s+1] <= den_ff[s];
            low_ff[s+1] <= low_in[s];
            quo_ff[s+1] <= quo_in[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quo = quo_ff[ST];
   assign ovf = ovf_ff[ST];

endmodule

// ===== hdl/rbr_back.sv =====
// rbr_back: reciprocal, tangent and secant pipeline, relaxation store and
// weight substitution, with a two-beat result queue; depends on rbr_pkg, rbr_divider
module rbr_back (
   input  logic             clock,
   input  logic             reset,
   input  rbr_pkg::job_type q_data,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output rbr_pkg::rsp_type rsp
);

   localparam int LAT = rbr_pkg::DIV_LAT;

   typedef struct packed {
      rbr_pkg::job_type job;
      logic [31:0]      bl;
      logic [31:0]      bu;
      logic [31:0]      rmid;
      logic [31:0]      dmid;
   } b_type;

   typedef struct packed {
      b_type       b;
      logic [31:0] lam;
   } e_type;

   typedef struct packed {
      e_type       e;
      logic [63:0] ph;
      logic [63:0] pl;
   } f_type;

   typedef struct packed {
      rbr_pkg::action_type       action;
      logic [rbr_pkg::IDX_W-1:0] neuron;
      logic [31:0]               wl;
      logic [31:0]               wu;
      logic                      status;
      logic [31:0]               bl;
      logic [31:0]               bu;
      logic [31:0]               ls;
      logic [31:0]               lo_off;
      logic [31:0]               hs;
      logic [31:0]               hi_off;
   } rec_type;

   typedef struct packed {
      rec_type     r;
      logic [63:0] p0;
      logic [63:0] p1;
      logic [63:0] p2;
      logic [63:0] p3;
   } i_type;

   function automatic logic [31:0] sat33(input logic signed [32:0] v);
      if (v > 33'sh0_7FFF_FFFF) begin
         return rbr_pkg::QMAX;
      end else if (v < 33'sh1_8000_0000) begin
         return rbr_pkg::QMIN;
      end
      return v[31:0];
   endfunction

   // product of two Q16.16 values, rounded half up and saturated
   function automatic logic [31:0] qround(input logic [63:0] p);
      logic signed [63:0] r;
      logic signed [47:0] q;
      r = $signed(p) + 64'sd32768;
      q = $signed(r[63:16]);
      if (q > 48'sh0000_7FFF_FFFF) begin
         return rbr_pkg::QMAX;
      end else if (q < 48'shFFFF_8000_0000) begin
         return rbr_pkg::QMIN;
      end
      return q[31:0];
   endfunction

   function automatic logic [31:0] recip_fix(input logic inf, input logic zero,
                                             input logic [31:0] q, input logic ov);
      if (inf) begin
         return 32'b0;
      end else if (zero || ov || q[31]) begin
         return rbr_pkg::QMAX;
      end
      return q;
   endfunction

   function automatic logic [31:0] deriv_fix(input logic inf, input logic zero,
                                             input logic [31:0] q, input logic ov);
      logic [31:0] mag;
      mag = (ov || q[31]) ? rbr_pkg::QMAX : q;
      if (inf) begin
         return 32'b0;
      end else if (zero) begin
         return rbr_pkg::QMIN;
      end
      return ~mag + 32'd1;
   endfunction

   logic en;

   // stage a
   rbr_pkg::job_type a_ff;
   logic             a_v_ff;
   logic [61:0]      sq_ff;

   // divider results
   logic [31:0] q_lo, q_hi, q_mid, q_der, q_sec;
   logic        o_lo, o_hi, o_mid, o_der, o_sec;

   rbr_pkg::job_type la_ff [LAT];
   logic [LAT-1:0]   la_v_ff;
   b_type            b_in, b_ff;
   logic             b_v_ff;
   b_type            lb_ff [LAT];
   logic [LAT-1:0]   lb_v_ff;
   e_type            e_in, e_ff;
   logic             e_v_ff;
   f_type            f_ff;
   logic             f_v_ff;
   logic [31:0]      pl_q, ph_q;
   rec_type          g_in, g_ff, h_ff;
   logic             g_v_ff, h_v_ff;
   logic [127:0]     tab_mem [rbr_pkg::NEURONS];
   logic [127:0]     rd_ff;
   i_type            i_in, i_ff;
   logic             i_v_ff;
   rbr_pkg::rsp_type o_in;

   // secant operands
   logic [32:0] nd, absn, dd, absdd;
   logic        neg;

   // result queue
   rbr_pkg::rsp_type oq_ff [2];
   logic             oq_w_ff, oq_r_ff;
   logic [1:0]       oq_cnt_ff;
   logic             oq_push, oq_pop;

   assign en    = (oq_cnt_ff != 2'd2);
   assign q_pop = en && !q_empty;

   rbr_divider u_div_lo (
      .clock (clock), .en (en),
      .num   ((62'd1 << 32) + {31'b0, a_ff.lo[31:1]}),
      .den   ({30'b0, a_ff.lo}),
      .quo   (q_lo), .ovf (o_lo)
   );

   rbr_divider u_div_hi (
      .clock (clock), .en (en),
      .num   ((62'd1 << 32) + {31'b0, a_ff.hi[31:1]}),
      .den   ({30'b0, a_ff.hi}),
      .quo   (q_hi), .ovf (o_hi)
   );

   rbr_divider u_div_mid (
      .clock (clock), .en (en),
      .num   ((62'd1 << 32) + {31'b0, a_ff.mid[31:1]}),
      .den   ({30'b0, a_ff.mid}),
      .quo   (q_mid), .ovf (o_mid)
   );

   // derivative magnitude 2^48 / mid^2
   rbr_divider u_div_der (
      .clock (clock), .en (en),
      .num   ((62'd1 << 48) + {1'b0, sq_ff[61:1]}),
      .den   (sq_ff),
      .quo   (q_der), .ovf (o_der)
   );

   // secant slope magnitude
   always_comb begin
      nd    = {1'b0, b_ff.bu} - {1'b0, b_ff.bl};
      absn  = nd[32] ? (33'd0 - nd) : nd;
      dd    = {1'b0, b_ff.job.lo} - {1'b0, b_ff.job.hi};
      absdd = dd[32] ? (33'd0 - dd) : dd;
   end

   rbr_divider u_div_sec (
      .clock (clock), .en (en),
      .num   ({13'b0, absn, 16'b0}),
      .den   ({29'b0, absdd}),
      .quo   (q_sec), .ovf (o_sec)
   );

   always_comb begin
      b_in.job  = la_ff[LAT-1];
      b_in.bu   = recip_fix(la_ff[LAT-1].lo_inf, la_ff[LAT-1].lo_zero, q_lo, o_lo);
      b_in.bl   = recip_fix(la_ff[LAT-1].hi_inf, la_ff[LAT-1].hi_zero, q_hi, o_hi);
      b_in.rmid = recip_fix(la_ff[LAT-1].mid_inf, la_ff[LAT-1].mid_zero, q_mid, o_mid);
      b_in.dmid = deriv_fix(la_ff[LAT-1].mid_inf, la_ff[LAT-1].mid_zero, q_der, o_der);
   end

   // sign of the slope follows both differences, truncated towards zero
   always_comb begin
      e_in.b = lb_ff[LAT-1];
      neg    = (e_in.b.bu < e_in.b.bl) ^ (e_in.b.job.lo < e_in.b.job.hi);
      if (!neg) begin
         e_in.lam = (o_sec || q_sec[31]) ? rbr_pkg::QMAX : q_sec;
      end else begin
         e_in.lam = (o_sec || (q_sec[31] && |q_sec[30:0])) ? rbr_pkg::QMIN : ~q_sec + 32'd1;
      end
   end

   assign pl_q = qround(f_ff.pl);
   assign ph_q = qround(f_ff.ph);

   always_comb begin
      g_in.action = f_ff.e.b.job.action;
      g_in.neuron = f_ff.e.b.job.neuron;
      g_in.wl     = f_ff.e.b.job.wl;
      g_in.wu     = f_ff.e.b.job.wu;
      g_in.status = f_ff.e.b.job.status;
      g_in.bl     = f_ff.e.b.bl;
      g_in.bu     = f_ff.e.b.bu;
      if (f_ff.e.b.job.equal) begin
         g_in.ls     = 32'b0;
         g_in.hs     = 32'b0;
         g_in.lo_off = f_ff.e.b.bl;
         g_in.hi_off = f_ff.e.b.bl;
      end else begin
         g_in.ls     = f_ff.e.b.dmid;
         g_in.hs     = f_ff.e.lam;
         g_in.lo_off = sat33($signed({f_ff.e.b.rmid[31], f_ff.e.b.rmid})
                             - $signed({pl_q[31], pl_q}));
         g_in.hi_off = sat33($signed({f_ff.e.b.bu[31], f_ff.e.b.bu})
                             - $signed({ph_q[31], ph_q}));
      end
   end

   // substitute picks lines by weight sign
   always_comb begin
      i_in.r = h_ff;
      if (h_ff.action == rbr_pkg::ACT_SUBST) begin
         {i_in.r.ls, i_in.r.lo_off, i_in.r.hs, i_in.r.hi_off} = rd_ff;
      end
      if (!h_ff.wl[31]) begin
         i_in.p0 = $signed(h_ff.wl) * $signed(i_in.r.ls);
         i_in.p1 = $signed(h_ff.wl) * $signed(i_in.r.lo_off);
      end else begin
         i_in.p0 = $signed(h_ff.wl) * $signed(i_in.r.hs);
         i_in.p1 = $signed(h_ff.wl) * $signed(i_in.r.hi_off);
      end
      if (!h_ff.wu[31]) begin
         i_in.p2 = $signed(h_ff.wu) * $signed(i_in.r.hs);
         i_in.p3 = $signed(h_ff.wu) * $signed(i_in.r.hi_off);
      end else begin
         i_in.p2 = $signed(h_ff.wu) * $signed(i_in.r.ls);
         i_in.p3 = $signed(h_ff.wu) * $signed(i_in.r.lo_off);
      end
   end

   always_comb begin
      o_in.low_slope   = i_ff.r.ls;
      o_in.low_offset  = i_ff.r.lo_off;
      o_in.high_slope  = i_ff.r.hs;
      o_in.high_offset = i_ff.r.hi_off;
      if (i_ff.r.action == rbr_pkg::ACT_RELAX) begin
         o_in.status            = i_ff.r.status;
         o_in.bound_lower       = i_ff.r.bl;
         o_in.bound_upper       = i_ff.r.bu;
         o_in.lower_coeff_delta = 32'b0;
         o_in.lower_bias_delta  = 32'b0;
         o_in.upper_coeff_delta = 32'b0;
         o_in.upper_bias_delta  = 32'b0;
      end else begin
         o_in.status            = 1'b0;
         o_in.bound_lower       = 32'b0;
         o_in.bound_upper       = 32'b0;
         o_in.lower_coeff_delta = qround(i_ff.p0);
         o_in.lower_bias_delta  = qround(i_ff.p1);
         o_in.upper_coeff_delta = qround(i_ff.p2);
         o_in.upper_bias_delta  = qround(i_ff.p3);
      end
   end

   assign oq_push = en && i_v_ff;
   assign oq_pop  = pop && (oq_cnt_ff != 2'd0);
   assign empty   = (oq_cnt_ff == 2'd0);
   assign rsp     = oq_ff[oq_r_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff    <= 1'b0;
         la_v_ff   <= '0;
         b_v_ff    <= 1'b0;
         lb_v_ff   <= '0;
         e_v_ff    <= 1'b0;
         f_v_ff    <= 1'b0;
         g_v_ff    <= 1'b0;
         h_v_ff    <= 1'b0;
         i_v_ff    <= 1'b0;
         oq_w_ff   <= 1'b0;
         oq_r_ff   <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (en) begin
            a_v_ff  <= !q_empty;
            la_v_ff <= {la_v_ff[LAT-2:0], a_v_ff};
            b_v_ff  <= la_v_ff[LAT-1];
            lb_v_ff <= {lb_v_ff[LAT-2:0], b_v_ff};
            e_v_ff  <= lb_v_ff[LAT-1];
            f_v_ff  <= e_v_ff;
            g_v_ff  <= f_v_ff;
            h_v_ff  <= g_v_ff;
            i_v_ff  <= h_v_ff;
         end
         if (oq_push) begin
            oq_w_ff <= ~oq_w_ff;
         end
         if (oq_pop) begin
            oq_r_ff <= ~oq_r_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= q_data;
         sq_ff    <= {31'b0, q_data.mid[30:0]} * {31'b0, q_data.mid[30:0]};
         la_ff[0] <= a_ff;
         for (int k = 1; k < LAT; k++) begin
            la_ff[k] <= la_ff[k-1];
            lb_ff[k] <= lb_ff[k-1];
         end
         b_ff     <= b_in;
         lb_ff[0] <= b_ff;
         e_ff     <= e_in;
         f_ff.e   <= e_ff;
         f_ff.ph  <= $signed(e_ff.lam) * $signed(e_ff.b.job.lo);
         f_ff.pl  <= $signed(e_ff.b.dmid) * $signed(e_ff.b.job.mid);
         g_ff     <= g_in;
         h_ff     <= g_ff;
         i_ff     <= i_in;
      end
      if (oq_push) begin
         oq_ff[oq_w_ff] <= o_in;
      end
   end

   // relaxation store: a relax writes as it leaves stage g, a later substitute reads there
   always_ff @(posedge clock) begin
      if (en) begin
         if (g_v_ff && (g_ff.action == rbr_pkg::ACT_RELAX)) begin
            tab_mem[g_ff.neuron] <= {g_ff.ls, g_ff.lo_off, g_ff.hs, g_ff.hi_off};
         end
         rd_ff <= tab_mem[g_ff.neuron];
      end
   end

endmodule

// ===== hdl/reciprocal_bound_relaxation.sv =====
// Reciprocal bound relaxation of y = 1/x in signed Q16.16. One item enters per clock
// while full is low and one result leaves per clock while pop is high; each item passes
// two 33-stage pipelined dividers in series (end-point reciprocals, then the secant
// slope). Relax and substitute items stay in order, so a substitute sees every earlier
// relax of its neuron. Full is set only when the result side stalls long enough to
// fill the item queue. Write equal_tolerance only while idle; the block does not check.
module reciprocal_bound_relaxation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_action,
   input  logic [7:0]                req_neuron,
   input  logic [31:0]               req_source_lower,
   input  logic [31:0]               req_source_upper,
   input  logic [31:0]               req_weight_lower,
   input  logic [31:0]               req_weight_upper,
   output logic                      empty,
   input  logic                      pop,
   output logic                      rsp_status,
   output logic [31:0]               rsp_bound_lower,
   output logic [31:0]               rsp_bound_upper,
   output logic [31:0]               rsp_low_slope,
   output logic [31:0]               rsp_low_offset,
   output logic [31:0]               rsp_high_slope,
   output logic [31:0]               rsp_high_offset,
   output logic [31:0]               rsp_lower_coeff_delta,
   output logic [31:0]               rsp_lower_bias_delta,
   output logic [31:0]               rsp_upper_coeff_delta,
   output logic [31:0]               rsp_upper_bias_delta,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [15:0]               csr_equal_tolerance
);

   logic [rbr_pkg::TOL_W-1:0] tol_ff;
   logic                      q_push, q_full, q_pop, q_empty;
   rbr_pkg::job_type          q_wdata, q_rdata;
   rbr_pkg::rsp_type          rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_equal_tolerance;
      end
   end

   rbr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .action       (req_action),
      .neuron       (req_neuron),
      .source_lower (req_source_lower),
      .source_upper (req_source_upper),
      .weight_lower (req_weight_lower),
      .weight_upper (req_weight_upper),
      .tolerance    (tol_ff),
      .q_push       (q_push),
      .q_data       (q_wdata),
      .q_full       (q_full)
   );

   rbr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   rbr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_rdata),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp)
   );

   assign rsp_status            = rsp.status;
   assign rsp_bound_lower       = rsp.bound_lower;
   assign rsp_bound_upper       = rsp.bound_upper;
   assign rsp_low_slope         = rsp.low_slope;
   assign rsp_low_offset        = rsp.low_offset;
   assign rsp_high_slope        = rsp.high_slope;
   assign rsp_high_offset       = rsp.high_offset;
   assign rsp_lower_coeff_delta = rsp.lower_coeff_delta;
   assign rsp_lower_bias_delta  = rsp.lower_bias_delta;
   assign rsp_upper_coeff_delta = rsp.upper_coeff_delta;
   assign rsp_upper_bias_delta  = rsp.upper_bias_delta;

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("back pulled from an empty item queue");

   a_full_needs_queue_full : assert property (@(posedge clock) disable iff (reset)
      full |-> q_full)
      else $error("input refused while the item queue had room");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> empty)
      else $error("result shown straight after reset");

endmodule
